/* rtl/telex_vowel_shape_rewriter_core_assert.svh */
// assertion macros for the telex vowel-shape rewriter
`ifndef TELEX_VOWEL_SHAPE_REWRITER_CORE_ASSERT_SVH
`define TELEX_VOWEL_SHAPE_REWRITER_CORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TVSR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define TVSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tvsr_pkg.sv */
// shared types and character codes for the telex vowel-shape rewriter
package tvsr_pkg;

   localparam int CHAR_W       = 8;
   localparam int BUNDLE_SLOTS = 4;
   localparam int SLOT_W       = 2;
   localparam int COUNT_W      = 3;
   localparam int LOOK_DEPTH   = 3;
   localparam int WORK_DEPTH   = 6;

   // shape markers
   localparam logic [CHAR_W-1:0] CH_UP_W = 8'h57;
   localparam logic [CHAR_W-1:0] CH_UP_U = 8'h55;
   localparam logic [CHAR_W-1:0] CH_UP_Q = 8'h51;
   localparam logic [CHAR_W-1:0] CH_UP_D = 8'h44;
   localparam logic [CHAR_W-1:0] CH_UP_B = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UP_E = 8'h45;
   localparam logic [CHAR_W-1:0] CH_UP_O = 8'h4F;
   localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;

   // plain letters that take part in rewrites
   localparam logic [CHAR_W-1:0] CH_LO_U = 8'h75;
   localparam logic [CHAR_W-1:0] CH_LO_D = 8'h64;
   localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_E = 8'h65;
   localparam logic [CHAR_W-1:0] CH_LO_O = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LO_W = 8'h77;

   // results caused by one input item, in output order
   typedef struct packed {
      logic [COUNT_W-1:0]                   count;
      logic [BUNDLE_SLOTS-1:0][CHAR_W-1:0]  chars;
      logic [BUNDLE_SLOTS-1:0]              lasts;
   } bundle_type;

endpackage

/* rtl/tvsr_req_if.sv */
// input channel carrying one rime byte per item
interface tvsr_req_if import tvsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              last_in;

   modport source (output valid, output char_in, output last_in, input ready);
   modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

/* rtl/tvsr_rsp_if.sv */
// result channel carrying one shaped byte per item
interface tvsr_rsp_if import tvsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last_out;

   modport source (output valid, output char_out, output last_out, input ready);
   modport sink   (input valid, input char_out, input last_out, output ready);
endinterface

/* rtl/telex_vowel_shape_rewriter_core.sv */
// top level of the telex vowel-shape rewriter
// Rewrites one Vietnamese rime, fed as lower-case bytes with last_in on the final
// byte, into shaped bytes with upper-case shape markers (W U Q D B E O A). The
// front accepts one item per cycle whenever the bundle queue has room; its step
// logic updates the lookahead and the held byte within that cycle, so the
// recurrence over that state is what sets the one-item-per-cycle input rate. Each
// item yields zero to four result items, packed in one bundle. The back drains
// bundles at one result item per cycle from its output register, so the input
// only stalls when results outrun items for longer than the queue
// (QUEUE_DEPTH bundles) can absorb, or when the result side stalls. The first
// result of an item is registered in the queue and then in the output register.
// After last_in all state is empty again and the next rime starts fresh.
`include "telex_vowel_shape_rewriter_core_assert.svh"

module telex_vowel_shape_rewriter_core import tvsr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   tvsr_req_if.sink    req_chan,
   tvsr_rsp_if.source  rsp_chan
);
   // front to queue
   logic       push_valid;
   bundle_type push_bundle;
   logic       queue_full;

   // queue to back
   logic       queue_pop;
   bundle_type head_bundle;
   logic       queue_empty;

   // lookahead, w pairing and shape resolution, one item per cycle while the queue has room
   tvsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   // decouples the two sides so each can stall on its own
   tvsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push_valid),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (queue_pop),
      .head_bundle (head_bundle),
      .empty       (queue_empty)
   );

   // serializes each bundle onto the result channel
   tvsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .rsp         (rsp_chan),
      .head_bundle (head_bundle),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop)
   );

   // the front never writes a bundle into a full queue
   `TVSR_ASSERT_IMPL(a_queue_no_overflow, push_valid, !queue_full, "bundle pushed into full queue")

   // the back never takes a bundle that is not there
   `TVSR_ASSERT_IMPL(a_queue_no_underflow, queue_pop, !queue_empty, "bundle popped from empty queue")

   // a queued bundle holds between one and four result items
   `TVSR_ASSERT_IMPL(a_bundle_count, push_valid, (push_bundle.count != '0) && (push_bundle.count <= COUNT_W'(BUNDLE_SLOTS)), "bundle count out of range")

   // leaving reset, no result is on offer
   `TVSR_ASSERT_NEXT(a_reset_idle, reset, !rsp_chan.valid, "result valid right after reset")
endmodule

/* rtl/tvsr_queue.sv */
// small fifo of result bundles between front and back
module tvsr_queue import tvsr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output bundle_type head_bundle,
   output logic       empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;

   assign full        = (fill_ff == CNT_W'(DEPTH));
   assign empty       = (fill_ff == '0);
   assign head_bundle = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end
endmodule

/* rtl/tvsr_front.sv */
// front: accepts bytes, pairs raw w's and resolves shapes into result bundles
module tvsr_front import tvsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tvsr_req_if.sink   req,
   input  logic       queue_full,
   output logic       push_valid,
   output bundle_type push_bundle
);
   logic [CHAR_W-1:0] look_ff [LOOK_DEPTH];
   logic [CHAR_W-1:0] look_in [LOOK_DEPTH];
   logic [1:0]        look_cnt_ff, look_cnt_in;
   logic [CHAR_W-1:0] held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic              accept;
   bundle_type        bundle;

   // bytes that may still combine with the next one
   function automatic logic waits_next(input logic [CHAR_W-1:0] ch);
      return (ch == CH_LO_U) || (ch == CH_LO_D) || (ch == CH_LO_A) ||
             (ch == CH_LO_E) || (ch == CH_LO_O) || (ch == CH_LO_W);
   endfunction

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      logic [WORK_DEPTH-1:0][CHAR_W-1:0] work;
      logic [2:0]         n;
      logic [2:0]         p;
      logic [2:0]         rem;
      logic [1:0]         cnt;
      logic [1:0]         lc;
      logic [1:0]         np;
      logic [1:0]         adv;
      logic [COUNT_W-1:0] oc;
      logic               pend;
      logic               brk;
      logic               fin;
      logic               hv;
      logic               has1;
      logic               has2;
      logic               modh;
      logic [CHAR_W-1:0]  a;
      logic [CHAR_W-1:0]  b;
      logic [CHAR_W-1:0]  c;
      logic [CHAR_W-1:0]  hd;
      logic [CHAR_W-1:0]  newhd;
      logic [CHAR_W-1:0]  b1;
      logic [CHAR_W-1:0]  b2;

      fin = req.last_in;
      cnt = look_cnt_ff;

      // a trailing raw w is still waiting for a partner
      unique case (cnt)
         2'd1:    pend = (look_ff[0] == CH_LO_W);
         2'd2:    pend = (look_ff[1] == CH_LO_W);
         2'd3:    pend = (look_ff[2] == CH_LO_W);
         default: pend = 1'b0;
      endcase
      if (pend) begin
         cnt = cnt - 2'd1;
      end

      work    = '0;
      work[0] = look_ff[0];
      work[1] = look_ff[1];
      work[2] = look_ff[2];
      n       = {1'b0, cnt};

      // first pass: ww pairs become the marker
      if (req.char_in == CH_LO_W) begin
         if (pend) begin
            work[n] = CH_UP_W;
            n       = n + 3'd1;
            pend    = 1'b0;
         end else begin
            pend = 1'b1;
         end
      end else begin
         if (pend) begin
            work[n] = CH_LO_W;
            n       = n + 3'd1;
         end
         work[n] = req.char_in;
         n       = n + 3'd1;
         pend    = 1'b0;
      end
      if (fin && pend) begin
         work[n] = CH_LO_W;
         n       = n + 3'd1;
         pend    = 1'b0;
      end

      hd     = held_ff;
      hv     = held_valid_ff;
      bundle = '0;
      oc     = '0;
      p      = '0;
      brk    = 1'b0;

      // second pass: each step consumes one to three bytes or ends the pass
      for (int it = 0; it < BUNDLE_SLOTS; it++) begin
         if (!brk && (p < n)) begin
            a     = work[p];
            b     = work[p + 3'd1];
            c     = work[p + 3'd2];
            has1  = (p + 3'd1) < n;
            has2  = (p + 3'd2) < n;
            np    = 2'd0;
            adv   = 2'd0;
            modh  = 1'b0;
            newhd = hd;
            b1    = a;
            b2    = a;

            priority if (a == CH_UP_W) begin
               np = 2'd1; b1 = CH_UP_W; adv = 2'd1;
            end else if (a == CH_LO_U && has1 && b == CH_LO_O && !has2 && !fin) begin
               brk = 1'b1;
            end else if (a == CH_LO_U && has1 && b == CH_LO_O && has2 && c == CH_LO_W) begin
               np = 2'd2; b1 = CH_UP_U; b2 = CH_UP_Q; adv = 2'd3;
            end else if (!has1 && !fin && waits_next(a)) begin
               brk = 1'b1;
            end else if (has1 && b == CH_UP_W) begin
               np = 2'd2; b1 = a; b2 = CH_UP_W; adv = 2'd2;
            end else if (has1 && a == CH_LO_D && b == CH_LO_D) begin
               np = 2'd1; b1 = CH_UP_D; adv = 2'd2;
            end else if (has1 && a == CH_LO_A && b == CH_LO_A) begin
               np = 2'd1; b1 = CH_UP_B; adv = 2'd2;
            end else if (has1 && a == CH_LO_E && (b == CH_LO_E || b == CH_LO_W)) begin
               np = 2'd1; b1 = CH_UP_E; adv = 2'd2;
            end else if (has1 && a == CH_LO_O && b == CH_LO_O) begin
               np = 2'd1; b1 = CH_UP_O; adv = 2'd2;
            end else if (has1 && a == CH_LO_U && b == CH_LO_W) begin
               np = 2'd1; b1 = CH_UP_U; adv = 2'd2;
            end else if (has1 && a == CH_LO_A && b == CH_LO_W && hv && hd == CH_LO_U) begin
               // "uaw": the held u takes the horn, a stays plain
               modh = 1'b1; newhd = CH_UP_U; np = 2'd1; b1 = CH_LO_A; adv = 2'd2;
            end else if (has1 && a == CH_LO_A && b == CH_LO_W) begin
               np = 2'd1; b1 = CH_UP_A; adv = 2'd2;
            end else if (has1 && a == CH_LO_O && b == CH_LO_W) begin
               np = 2'd1; b1 = CH_UP_Q; adv = 2'd2;
            end else if (a == CH_LO_W) begin
               // lone w reshapes the held vowel or stands as U
               adv = 2'd1;
               if (hv && hd == CH_LO_A) begin
                  modh = 1'b1; newhd = CH_UP_A;
               end else if (hv && hd == CH_LO_O) begin
                  modh = 1'b1; newhd = CH_UP_Q;
               end else if (hv && hd == CH_LO_U) begin
                  modh = 1'b1; newhd = CH_UP_U;
               end else begin
                  np = 2'd1; b1 = CH_UP_U;
               end
            end else begin
               np = 2'd1; b1 = a; adv = 2'd1;
            end

            if (modh) begin
               hd = newhd;
            end
            if (np != 2'd0) begin
               if (hv && oc < COUNT_W'(BUNDLE_SLOTS)) begin
                  bundle.chars[oc[SLOT_W-1:0]] = hd;
                  bundle.lasts[oc[SLOT_W-1:0]] = 1'b0;
                  oc = oc + 1'b1;
               end
               hd = b1;
               hv = 1'b1;
            end
            if (np == 2'd2) begin
               if (oc < COUNT_W'(BUNDLE_SLOTS)) begin
                  bundle.chars[oc[SLOT_W-1:0]] = hd;
                  bundle.lasts[oc[SLOT_W-1:0]] = 1'b0;
                  oc = oc + 1'b1;
               end
               hd = b2;
            end
            p = p + {1'b0, adv};
         end
      end

      for (int i = 0; i < LOOK_DEPTH; i++) begin
         look_in[i] = '0;
      end
      look_cnt_in = '0;
      rem         = n - p;

      if (fin) begin
         // end of rime: release the held byte and start empty
         if (hv && oc < COUNT_W'(BUNDLE_SLOTS)) begin
            bundle.chars[oc[SLOT_W-1:0]] = hd;
            bundle.lasts[oc[SLOT_W-1:0]] = 1'b1;
            oc = oc + 1'b1;
         end
         held_in       = '0;
         held_valid_in = 1'b0;
      end else begin
         lc = (rem >= 3'd3) ? 2'd3 : rem[1:0];
         for (int i = 0; i < LOOK_DEPTH; i++) begin
            if (i < int'(lc)) begin
               look_in[i] = work[p + 3'(i)];
            end
         end
         if (pend && lc < 2'd3) begin
            look_in[lc] = CH_LO_W;
            lc          = lc + 2'd1;
         end
         look_cnt_in   = lc;
         held_in       = hd;
         held_valid_in = hv;
      end

      bundle.count = oc;
   end

   assign push_valid  = accept && (bundle.count != '0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOOK_DEPTH; i++) begin
            look_ff[i] <= '0;
         end
         look_cnt_ff   <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         for (int i = 0; i < LOOK_DEPTH; i++) begin
            look_ff[i] <= look_in[i];
         end
         look_cnt_ff   <= look_cnt_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end
endmodule

/* rtl/tvsr_back.sv */
// back: takes bundles from the queue and delivers one shaped byte per cycle while the result side is ready
module tvsr_back import tvsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tvsr_rsp_if.source  rsp,
   input  bundle_type  head_bundle,
   input  logic        queue_empty,
   output logic        queue_pop
);
   bundle_type        cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              take;
   logic              final_slot;
   logic              free;

   assign rsp.valid    = cur_valid_ff;
   assign rsp.char_out = cur_ff.chars[slot_ff];
   assign rsp.last_out = cur_ff.lasts[slot_ff];

   assign take       = rsp.valid && rsp.ready;
   assign final_slot = (slot_ff == SLOT_W'(cur_ff.count - 1'b1));
   assign free       = !cur_valid_ff || (take && final_slot);
   assign queue_pop  = free && !queue_empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      slot_in      = slot_ff;
      if (free) begin
         cur_in       = head_bundle;
         cur_valid_in = !queue_empty;
         slot_in      = '0;
      end else if (take) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end
endmodule
